### design/ssfm_pkg.sv
// shared constants, types and helpers for the streaming substring search
`timescale 1ns / 1ps

package ssfm_pkg;

  // window capacity in cells
  localparam int MaxNeedle   = 16;
  // width of the haystack byte counter
  localparam int OffsetWidth = 32;

  // fixed by the needle registers and the result fields
  localparam int NeedleCap   = 16;
  localparam int NeedleW     = 8 * NeedleCap;
  localparam int LenW        = 5;
  localparam int OutOffsetW  = 32;
  localparam int CfgIdxW     = 2;
  localparam int CfgDataW    = 64;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgNeedleLow  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgNeedleHigh = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNeedleLen  = 2'd2;

  // per-cycle control handed to every window cell
  typedef struct packed {
    logic shift;
    logic clear;
  } ssfm_cell_ctrl_t;

  // needle byte at a position, zero outside the needle registers
  function automatic logic [7:0] needle_byte(input logic [NeedleW-1:0] needle, input int pos);
    logic [7:0] res;
    res = 8'h00;
    if (pos >= 0 && pos < NeedleCap) begin
      res = needle[8*pos +: 8];
    end
    return res;
  endfunction

endpackage

### design/streaming_substring_first_match_unit.sv
// top level of the streaming first-match substring search
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_ready_o, data_byte_i, last_byte_i | in
//   out     | out_valid_o, out_ready_i, found_o, match_offset_o | out
//   cfg     | cfg_we_i, cfg_index_i, cfg_wdata_i        | in
//
// one haystack byte per cycle while in_ready_o is high; a result is registered and appears in the cycle after its byte
// the window shift, per-cell compare and offset subtract share the cycle the byte is taken in
// the output register hands its result on in the cycle the next byte enters
// input stalls only while a result is held and out_ready_i is low
// reset clears the window, the byte count, the match flag and the needle
`timescale 1ns / 1ps

module streaming_substring_first_match_unit
  import ssfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  found_o,
  output logic [OutOffsetW-1:0] match_offset_o,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i
);

  localparam int ExtW = (OffsetWidth > OutOffsetW) ? OffsetWidth : OutOffsetW;

  logic [CfgDataW-1:0]    needle_lo_q, needle_hi_q;
  logic [LenW-1:0]        needle_len_q;
  logic [NeedleW-1:0]     needle;
  logic [OffsetWidth-1:0] count_q, count_d, count_inc, offset_full;
  logic                   reported_q, reported_d;
  logic                   out_valid_q, out_valid_d;
  logic                   found_q, found_d;
  logic [OutOffsetW-1:0]  offset_q, offset_d;
  logic [ExtW-1:0]        offset_ext;
  logic                   in_acc, len_ok, hit, all_match, count_ok;
  ssfm_cell_ctrl_t        cell_ctrl;
  logic [7:0]             cell_in   [MaxNeedle];
  logic [7:0]             cell_out  [MaxNeedle];
  logic [7:0]             cell_exp  [MaxNeedle];
  logic [MaxNeedle-1:0]   cell_en, cell_match;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      needle_lo_q  <= '0;
      needle_hi_q  <= '0;
      needle_len_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CfgNeedleLow:  needle_lo_q  <= cfg_wdata_i;
        CfgNeedleHigh: needle_hi_q  <= cfg_wdata_i;
        CfgNeedleLen:  needle_len_q <= cfg_wdata_i[LenW-1:0];
        default: ;
      endcase
    end
  end

  assign needle = {needle_hi_q, needle_lo_q};
  assign len_ok = (needle_len_q != '0) && (int'(needle_len_q) <= NeedleCap) &&
                  (int'(needle_len_q) <= MaxNeedle);

  // handshake
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  // cell control: no shift once this haystack has reported
  always_comb begin
    cell_ctrl.shift = in_acc && !reported_q;
    cell_ctrl.clear = in_acc && last_byte_i;
  end

  // chain of window cells, cell 0 takes the newest byte
  for (genvar k = 0; k < MaxNeedle; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = data_byte_i;
    end else begin : g_body
      assign cell_in[k] = cell_out[k-1];
    end
    assign cell_en[k]  = len_ok && (k < int'(needle_len_q));
    assign cell_exp[k] = needle_byte(needle, int'(needle_len_q) - 1 - k);

    ssfm_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .byte_i   (cell_in[k]),
      .expect_i (cell_exp[k]),
      .cmp_en_i (cell_en[k]),
      .byte_o   (cell_out[k]),
      .match_o  (cell_match[k])
    );
  end

  // saturating byte count including the byte taken now
  assign count_inc = (&count_q) ? count_q : count_q + 1'b1;
  assign count_ok  = count_inc >= OffsetWidth'(needle_len_q);
  assign all_match = &cell_match;
  assign hit       = (needle_len_q == '0) || (len_ok && count_ok && all_match);

  assign offset_full = (needle_len_q == '0) ? '0 : count_inc - OffsetWidth'(needle_len_q);
  assign offset_ext  = ExtW'(offset_full);

  // stream state and result register
  always_comb begin
    count_d     = count_q;
    reported_d  = reported_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    offset_d    = offset_q;
    if (in_acc) begin
      if (!reported_q) begin
        count_d = count_inc;
        if (hit) begin
          out_valid_d = 1'b1;
          found_d     = 1'b1;
          offset_d    = offset_ext[OutOffsetW-1:0];
          reported_d  = 1'b1;
        end else if (last_byte_i) begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          offset_d    = '0;
        end
      end
      if (last_byte_i) begin
        count_d    = '0;
        reported_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      reported_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      reported_q  <= reported_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    found_q  <= found_d;
    offset_q <= offset_d;
  end

  assign out_valid_o    = out_valid_q;
  assign found_o        = found_q;
  assign match_offset_o = offset_q;

  // a reported haystack absorbs bytes without results
  a_silent_after_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && reported_q |=> !out_valid_o)
    else $error("result produced after match was reported");

  // last byte leaves a clean stream state
  a_clear_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> (count_q == '0) && !reported_q)
    else $error("stream state not cleared after last byte");

  // a match that is not on the last byte marks the haystack as reported
  a_mark_reported: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !reported_q && hit && !last_byte_i |=> reported_q && out_valid_o && found_o)
    else $error("match not recorded");

  // not-found results carry a zero offset
  a_notfound_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !found_o |-> (match_offset_o == '0))
    else $error("not-found result with nonzero offset");

endmodule

### design/ssfm_cell.sv
// one window cell: holds a haystack byte, passes it on, compares the incoming byte
`timescale 1ns / 1ps

module ssfm_cell
  import ssfm_pkg::*;
(
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ssfm_cell_ctrl_t ctrl_i,
  input  logic [7:0]      byte_i,
  input  logic [7:0]      expect_i,
  input  logic            cmp_en_i,
  output logic [7:0]      byte_o,
  output logic            match_o
);

  logic [7:0] byte_q, byte_d;

  // shift in from the neighbor, or clear for the next haystack
  always_comb begin
    byte_d = byte_q;
    if (ctrl_i.clear) begin
      byte_d = 8'h00;
    end else if (ctrl_i.shift) begin
      byte_d = byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_q <= 8'h00;
    end else begin
      byte_q <= byte_d;
    end
  end

  // compare the byte this cell takes in now; cells past the needle always agree
  assign match_o = !cmp_en_i || (byte_i == expect_i);
  assign byte_o  = byte_q;

endmodule

### verif/ssfm_checker.sv
// checker for the substring search: follows the channels, predicts results and compares them
`timescale 1ns / 1ps

module ssfm_checker
  import ssfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_ready_i,
  input  logic [7:0]            data_byte_i,
  input  logic                  last_byte_i,
  input  logic                  out_valid_i,
  input  logic                  out_ready_i,
  input  logic                  found_i,
  input  logic [OutOffsetW-1:0] match_offset_i,
  input  logic                  cfg_we_i,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [CfgDataW-1:0]   cfg_wdata_i,
  output int                    mismatch_count_o,
  output int                    outstanding_o
);

  typedef struct packed {
    logic                  found;
    logic [OutOffsetW-1:0] offset;
  } search_result_t;

  // mirrored needle registers
  logic [CfgDataW-1:0]    pat_low;
  logic [CfgDataW-1:0]    pat_high;
  logic [LenW-1:0]        pat_len;

  // mirrored haystack state, entry 0 is the newest byte
  logic [7:0]             hay_window [MaxNeedle];
  logic [OffsetWidth-1:0] hay_count;
  logic                   hit_done;

  search_result_t         expected_results[$];
  int                     mismatches;

  initial begin
    mismatch_count_o = 0;
    outstanding_o    = 0;
  end

  function automatic logic [7:0] pattern_byte(input int pos);
    logic [7:0] res;
    res = 8'h00;
    if (pos < 8) begin
      res = pat_low[8*pos +: 8];
    end else if (pos < 16) begin
      res = pat_high[8*(pos-8) +: 8];
    end
    return res;
  endfunction

  task automatic clear_haystack();
    int k;
    for (k = 0; k < MaxNeedle; k++) begin
      hay_window[k] = 8'h00;
    end
    hay_count = '0;
    hit_done  = 1'b0;
  endtask

  // one accepted haystack byte: shift, count, compare, maybe queue a result
  task automatic search_step(input logic [7:0] b, input logic last);
    search_result_t         res;
    logic [OffsetWidth-1:0] diff;
    int                     len;
    int                     k;
    bit                     hit;
    if (hit_done) begin
      if (last) begin
        clear_haystack();
      end
      return;
    end
    for (k = MaxNeedle - 1; k > 0; k--) begin
      hay_window[k] = hay_window[k-1];
    end
    hay_window[0] = b;
    // count stops at its maximum
    if (hay_count != '1) begin
      hay_count = hay_count + 1'b1;
    end
    len = pat_len;
    hit = 1'b0;
    diff = '0;
    if (len == 0) begin
      hit = 1'b1;
    end else if (len <= NeedleCap && len <= MaxNeedle && hay_count >= len) begin
      hit = 1'b1;
      for (k = 0; k < len; k++) begin
        if (hay_window[len-1-k] != pattern_byte(k)) begin
          hit = 1'b0;
        end
      end
      diff = hay_count - OffsetWidth'(len);
    end
    if (hit) begin
      res.found  = 1'b1;
      res.offset = OutOffsetW'(diff);
      expected_results.push_back(res);
      if (last) begin
        clear_haystack();
      end else begin
        hit_done = 1'b1;
      end
    end else if (last) begin
      res.found  = 1'b0;
      res.offset = '0;
      expected_results.push_back(res);
      clear_haystack();
    end
  endtask

  // results are retired before the byte of this edge is predicted
  always @(posedge clk_i or negedge rst_ni) begin : watch
    search_result_t want;
    if (!rst_ni) begin
      pat_low  = '0;
      pat_high = '0;
      pat_len  = '0;
      clear_haystack();
      expected_results.delete();
      mismatches = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result transaction: found %0b offset %0d", found_i,
                 match_offset_i);
          mismatches++;
        end else begin
          want = expected_results.pop_front();
          if (found_i !== want.found) begin
            $error("found: expected %0b, actual %0b", want.found, found_i);
            mismatches++;
          end
          if (match_offset_i !== want.offset) begin
            $error("match_offset: expected %0d, actual %0d", want.offset, match_offset_i);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgNeedleLow: begin
            pat_low = cfg_wdata_i;
          end
          CfgNeedleHigh: begin
            pat_high = cfg_wdata_i;
          end
          CfgNeedleLen: begin
            pat_len = cfg_wdata_i[LenW-1:0];
          end
          default: begin
          end
        endcase
      end
      if (in_valid_i && in_ready_i) begin
        search_step(data_byte_i, last_byte_i);
      end
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= expected_results.size();
  end

endmodule

### verif/tb_top.sv
// testbench top: stimulus for the substring search, the block, its checker and the verdict
`timescale 1ns / 1ps

module tb_top
  import ssfm_pkg::*;
();

  localparam int RandomItems = 750;

  logic                  clk_i;
  logic                  rst_ni         = 1'b0;
  logic                  in_valid_i     = 1'b0;
  logic                  in_ready_o;
  logic [7:0]            data_byte_i    = 8'h00;
  logic                  last_byte_i    = 1'b0;
  logic                  out_valid_o;
  logic                  out_ready_i    = 1'b0;
  logic                  found_o;
  logic [OutOffsetW-1:0] match_offset_o;
  logic                  cfg_we_i       = 1'b0;
  logic [CfgIdxW-1:0]    cfg_index_i    = CfgNeedleLow;
  logic [CfgDataW-1:0]   cfg_wdata_i    = '0;

  int          mismatches;
  int          outstanding;
  int          bytes_sent     = 0;
  int unsigned send_idle_pct  = 17;
  int unsigned recv_idle_pct  = 53;

  streaming_substring_first_match_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .data_byte_i    (data_byte_i),
    .last_byte_i    (last_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .found_o        (found_o),
    .match_offset_o (match_offset_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_wdata_i    (cfg_wdata_i)
  );

  ssfm_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_i       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_i      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_i          (found_o),
    .match_offset_i   (match_offset_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_index_i      (cfg_index_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // result side backpressure
  always @(posedge clk_i) begin
    out_ready_i <= rst_ni && ($urandom_range(99) >= recv_idle_pct);
  end

  // run limit
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  // sender and receiver idle rates follow the progress of the run
  task automatic set_idle_mode();
    if (bytes_sent < RandomItems / 3) begin
      send_idle_pct = 17;
      recv_idle_pct = 53;
    end else if (bytes_sent < 2 * RandomItems / 3) begin
      send_idle_pct = 53;
      recv_idle_pct = 17;
    end else begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end
  endtask

  // wait until every predicted result has been taken, then let the pipe settle
  task automatic drain();
    @(posedge clk_i);
    while (outstanding != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_needle(input logic [NeedleW-1:0] pat, input logic [LenW-1:0] len);
    drain();
    write_reg(CfgNeedleLow, pat[63:0]);
    write_reg(CfgNeedleHigh, pat[127:64]);
    write_reg(CfgNeedleLen, CfgDataW'(len));
    cfg_we_i <= 1'b0;
  endtask

  // one byte transaction, with an optional idle gap in front
  task automatic send_byte(input logic [7:0] b, input logic last);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i  <= 1'b1;
    data_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
    bytes_sent++;
  endtask

  task automatic send_haystack(input logic [7:0] hay[$]);
    int k;
    for (k = 0; k < hay.size(); k++) begin
      send_byte(hay[k], k == hay.size() - 1);
    end
  endtask

  // one needle setting and a run of haystacks built around it
  task automatic run_phase(input int phase_idx, input int phase_items);
    logic [NeedleW-1:0] pat;
    logic [7:0]         hay[$];
    logic [7:0]         sym_a;
    logic [7:0]         sym_b;
    int                 len;
    int                 eff;
    int                 sel;
    int                 hl;
    int                 pos;
    int                 k;
    int                 goal;
    int                 kind;
    bit                 narrow;
    sel = (phase_idx < 8) ? phase_idx : $urandom_range(9);
    case (sel)
      0:       len = 0;
      1:       len = 16;
      2:       len = 1;
      3:       len = $urandom_range(17, 31);
      4:       len = 8;
      5:       len = 9;
      6:       len = 15;
      default: len = $urandom_range(2, 6);
    endcase
    sym_a  = $urandom;
    sym_b  = $urandom;
    narrow = $urandom_range(1);
    for (k = 0; k < NeedleCap; k++) begin
      pat[8*k +: 8] = narrow ? ($urandom_range(1) ? sym_a : sym_b) : 8'($urandom);
    end
    load_needle(pat, LenW'(len));
    eff  = (len > NeedleCap) ? NeedleCap : len;
    goal = bytes_sent + phase_items;
    while (bytes_sent < goal) begin
      set_idle_mode();
      hay.delete();
      hl = ($urandom_range(9) == 0) ? $urandom_range(1, 80) : $urandom_range(1, 30);
      // filler drawn mostly from needle bytes so partial matches are common
      for (k = 0; k < hl; k++) begin
        if (narrow && $urandom_range(3) != 0) begin
          hay.push_back($urandom_range(1) ? sym_a : sym_b);
        end else if ($urandom_range(1)) begin
          hay.push_back(pat[8*$urandom_range(NeedleCap-1) +: 8]);
        end else begin
          hay.push_back(8'($urandom));
        end
      end
      kind = $urandom_range(9);
      if (kind < 8 && eff > 0) begin
        while (hay.size() < eff) begin
          hay.push_back(8'($urandom));
        end
        pos = $urandom_range(hay.size() - eff);
        for (k = 0; k < eff; k++) begin
          hay[pos+k] = pat[8*k +: 8];
        end
        // broken copy: last needle byte disturbed
        if (kind >= 6) begin
          hay[pos+eff-1] = hay[pos+eff-1] ^ (8'h01 << $urandom_range(7));
        end
      end
      send_haystack(hay);
      if ($urandom_range(19) == 0) begin
        in_valid_i <= 1'b0;
        drain();
      end
    end
  endtask

  // stimulus
  initial begin : stim
    logic [7:0]         hay[$];
    logic [NeedleW-1:0] pat;
    int                 k;
    int                 phase_idx;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset needle is empty: first byte hits, rest absorbed
    set_idle_mode();
    hay = '{8'h00};
    send_haystack(hay);
    hay = '{8'hFF, 8'h12, 8'h34};
    send_haystack(hay);

    // full-length needle matching on the last byte
    in_valid_i <= 1'b0;
    pat = {64'h7766554433221100, 64'hFFEEDDCCBBAA9988};
    load_needle(pat, LenW'(16));
    hay.delete();
    for (k = 0; k < NeedleCap; k++) begin
      hay.push_back(pat[8*k +: 8]);
    end
    send_haystack(hay);

    // single byte needle, match at offset one on the last byte
    in_valid_i <= 1'b0;
    load_needle('0, LenW'(1));
    hay = '{8'h01, 8'h00};
    send_haystack(hay);

    // needle longer than the window never matches
    in_valid_i <= 1'b0;
    load_needle('0, LenW'(17));
    hay = '{8'h00, 8'h00};
    send_haystack(hay);

    // random part
    bytes_sent = 0;
    phase_idx  = 0;
    while (bytes_sent < RandomItems) begin
      in_valid_i <= 1'b0;
      run_phase(phase_idx, $urandom_range(30, 70));
      phase_idx++;
    end

    in_valid_i <= 1'b0;
    drain();
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### filelist.f
design/ssfm_pkg.sv
design/ssfm_cell.sv
design/streaming_substring_first_match_unit.sv
verif/ssfm_checker.sv
verif/tb_top.sv
